FILE: hdl/mlfc_pkg.sv
// Shared types and constants of the multi-LED flash controller.
package mlfc_pkg;

  // Number of LEDs driven by the controller.
  localparam int LED_NUM = 4;

  // Field widths of the command transaction.
  localparam int ACTION_W = 3;
  localparam int SEL_W    = 3;
  localparam int FIELD_W  = 16;

  // Command codes.
  localparam logic [ACTION_W-1:0] ACT_ON         = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_OFF        = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FLASH_GO   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FLASH_STOP = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;

  // Selector value that addresses every LED at once.
  localparam logic [SEL_W-1:0] SEL_ALL = SEL_W'(LED_NUM);

  // One command transaction.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SEL_W-1:0]    led_select;
    logic [FIELD_W-1:0]  bright_ticks;
    logic [FIELD_W-1:0]  dark_ticks;
    logic [FIELD_W-1:0]  flash_cycles;
  } led_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [LED_NUM-1:0] pin_levels;
    logic [LED_NUM-1:0] flash_done;
  } led_result_t;

endpackage

FILE: hdl/multi_led_flash_controller.sv
// Top level of the multi-LED flash controller: command register, LED state and result register.
// Every accepted command transaction (on, off, toggle, start flash, stop flash or tick) yields
// exactly one result transaction carrying the pin level of each LED, after polarity, and its
// flash-done flag. The block takes one transaction per clock cycle while the result channel
// is not stalled. A command passes through the command register and then the result register,
// where its result is presented. The per-LED state update is combinational, between the
// command register and the result register. A tick advances every flashing LED with a nonzero
// dark time in parallel, each with its own small phase and cycle counters. The polarity register
// active_high_mask is written through cfg_wr_en/cfg_wr_data; the user must write it only while
// no transaction is in flight, as the block itself does not enforce this.
module multi_led_flash_controller
  import mlfc_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // Command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  led_cmd_t            in_data,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output led_result_t         out_data,
  // Configuration port
  input  logic                cfg_wr_en,
  input  logic [LED_NUM-1:0]  cfg_wr_data
);

  typedef logic [TIME_BITS-1:0] time_t;

  // Pipeline control and payload.
  logic         s1_valid_r;
  led_cmd_t     s1_data_r;
  logic         out_valid_r;
  led_result_t  out_data_r;
  led_result_t  result_nxt;
  logic         out_free;
  logic         s1_load;
  logic         out_load;

  // Configuration.
  logic [LED_NUM-1:0] active_high_mask_r;

  // Per-LED state.
  logic  led_lit_r      [LED_NUM];
  logic  flash_enable_r [LED_NUM];
  logic  dark_phase_r   [LED_NUM];
  time_t phase_count_r  [LED_NUM];
  time_t cycles_done_r  [LED_NUM];
  time_t lit_time_r     [LED_NUM];
  time_t unlit_time_r   [LED_NUM];
  time_t cycle_target_r [LED_NUM];

  logic  led_lit_nxt      [LED_NUM];
  logic  flash_enable_nxt [LED_NUM];
  logic  dark_phase_nxt   [LED_NUM];
  time_t phase_count_nxt  [LED_NUM];
  time_t cycles_done_nxt  [LED_NUM];
  time_t lit_time_nxt     [LED_NUM];
  time_t unlit_time_nxt   [LED_NUM];
  time_t cycle_target_nxt [LED_NUM];

  // Helpers of the update.
  logic  led_hit    [LED_NUM];
  time_t pc_inc     [LED_NUM];
  time_t cd_sat     [LED_NUM];
  time_t lit_in;
  time_t dark_in;
  time_t cyc_in;

  // Handshake: the result register frees when empty or when its transaction is taken.
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign s1_load   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Command fields cut or widened to the timer width.
  assign lit_in  = TIME_BITS'(s1_data_r.bright_ticks);
  assign dark_in = TIME_BITS'(s1_data_r.dark_ticks);
  assign cyc_in  = TIME_BITS'(s1_data_r.flash_cycles);

  // LED selection and counter increments, one set per LED.
  always_comb begin
    for (int i = 0; i < LED_NUM; i++) begin
      led_hit[i] = (s1_data_r.led_select == SEL_W'(i)) || (s1_data_r.led_select == SEL_ALL);
      pc_inc[i]  = phase_count_r[i] + time_t'(1);
      cd_sat[i]  = (cycles_done_r[i] != '1) ? cycles_done_r[i] + time_t'(1) : cycles_done_r[i];
    end
  end

  // Next LED state for the command in the command register.
  always_comb begin
    led_lit_nxt      = led_lit_r;
    flash_enable_nxt = flash_enable_r;
    dark_phase_nxt   = dark_phase_r;
    phase_count_nxt  = phase_count_r;
    cycles_done_nxt  = cycles_done_r;
    lit_time_nxt     = lit_time_r;
    unlit_time_nxt   = unlit_time_r;
    cycle_target_nxt = cycle_target_r;

    unique case (s1_data_r.action)
      ACT_ON: begin
        for (int i = 0; i < LED_NUM; i++) begin
          if (led_hit[i]) led_lit_nxt[i] = 1'b1;
        end
      end
      ACT_OFF: begin
        for (int i = 0; i < LED_NUM; i++) begin
          if (led_hit[i]) led_lit_nxt[i] = 1'b0;
        end
      end
      ACT_TOGGLE: begin
        for (int i = 0; i < LED_NUM; i++) begin
          if (led_hit[i]) led_lit_nxt[i] = !led_lit_r[i];
        end
      end
      ACT_FLASH_GO: begin
        // A zero lit time leaves the LED untouched.
        for (int i = 0; i < LED_NUM; i++) begin
          if (led_hit[i] && (lit_in != '0)) begin
            lit_time_nxt[i]     = lit_in;
            unlit_time_nxt[i]   = dark_in;
            cycle_target_nxt[i] = cyc_in;
            phase_count_nxt[i]  = '0;
            dark_phase_nxt[i]   = 1'b0;
            cycles_done_nxt[i]  = '0;
            flash_enable_nxt[i] = 1'b1;
            led_lit_nxt[i]      = 1'b1;
          end
        end
      end
      ACT_FLASH_STOP: begin
        // The dark phase flag is left as it stands.
        for (int i = 0; i < LED_NUM; i++) begin
          if (led_hit[i]) begin
            lit_time_nxt[i]     = '0;
            unlit_time_nxt[i]   = '0;
            phase_count_nxt[i]  = '0;
            flash_enable_nxt[i] = 1'b0;
            cycle_target_nxt[i] = '0;
            cycles_done_nxt[i]  = '0;
            led_lit_nxt[i]      = 1'b0;
          end
        end
      end
      ACT_TICK: begin
        // Every flashing LED with a nonzero dark time advances, whatever the selector.
        for (int i = 0; i < LED_NUM; i++) begin
          if (flash_enable_r[i] && (unlit_time_r[i] != '0)) begin
            phase_count_nxt[i] = pc_inc[i];
            if (!dark_phase_r[i]) begin
              if (pc_inc[i] >= lit_time_r[i]) begin
                led_lit_nxt[i]     = 1'b0;
                phase_count_nxt[i] = '0;
                dark_phase_nxt[i]  = 1'b1;
              end
            end else if (pc_inc[i] >= unlit_time_r[i]) begin
              if ((cycle_target_r[i] != '0) && (cycle_target_r[i] != '1)) begin
                cycles_done_nxt[i] = cd_sat[i];
              end
              if ((cycle_target_r[i] != '0) && (cycle_target_r[i] != '1) &&
                  (cd_sat[i] >= cycle_target_r[i])) begin
                // Last cycle finished: the LED stays dark.
                flash_enable_nxt[i] = 1'b0;
                unlit_time_nxt[i]   = '0;
              end else begin
                phase_count_nxt[i] = '0;
                dark_phase_nxt[i]  = 1'b0;
                led_lit_nxt[i]     = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields from the updated state.
  always_comb begin
    for (int i = 0; i < LED_NUM; i++) begin
      result_nxt.pin_levels[i] = led_lit_nxt[i] ~^ active_high_mask_r[i];
      result_nxt.flash_done[i] = cycles_done_nxt[i] >= cycle_target_nxt[i];
    end
  end

  // Pipeline control and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      active_high_mask_r <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        active_high_mask_r <= cfg_wr_data;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= result_nxt;
    end
  end

  // LED state, updated as a transaction moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_NUM; i++) begin
        led_lit_r[i]      <= 1'b0;
        flash_enable_r[i] <= 1'b0;
        dark_phase_r[i]   <= 1'b0;
        phase_count_r[i]  <= '0;
        cycles_done_r[i]  <= '0;
        lit_time_r[i]     <= '0;
        unlit_time_r[i]   <= '0;
        cycle_target_r[i] <= '0;
      end
    end else if (out_load) begin
      led_lit_r      <= led_lit_nxt;
      flash_enable_r <= flash_enable_nxt;
      dark_phase_r   <= dark_phase_nxt;
      phase_count_r  <= phase_count_nxt;
      cycles_done_r  <= cycles_done_nxt;
      lit_time_r     <= lit_time_nxt;
      unlit_time_r   <= unlit_time_nxt;
      cycle_target_r <= cycle_target_nxt;
    end
  end

  // The command side stalls only while a command waits on a blocked result.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("command stall without a waiting transaction");

  // A command that leaves the command register shows up as a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("processed command produced no result");

  // Per-LED flash invariants.
  for (genvar g = 0; g < LED_NUM; g++) begin : g_led_chk
    a_flash_has_lit_time: assert property (@(posedge clk) disable iff (!rst_n)
      flash_enable_r[g] |-> (lit_time_r[g] != '0))
      else $error("flash running with zero lit time");

    a_cycles_below_target: assert property (@(posedge clk) disable iff (!rst_n)
      (flash_enable_r[g] && (cycle_target_r[g] != '0) && (cycle_target_r[g] != '1))
        |-> (cycles_done_r[g] < cycle_target_r[g]))
      else $error("finite flash still running at its cycle target");
  end

endmodule
